// ----- rtl/tapa_pkg.sv -----
`timescale 1ns / 1ps

package tapa_pkg;

   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

   localparam int PULSE_W   = 16;
   localparam int ANGLE_W   = 16;
   localparam int CLAMP_W   = 11;
   localparam int DIFF_W    = 10;
   localparam int ERR_W     = 17;
   localparam int DERIV_W   = ERR_W + 1;
   localparam int SUM_W     = 25;
   localparam int ILIM_W    = 24;
   localparam int GAIN_W    = 16;
   localparam int GAINS_W   = 3 * GAIN_W;
   localparam int DLIM_W    = 10;
   localparam int DRIVE_W   = 11;
   localparam int CSR_W     = GAINS_W;
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_W    = 16;

   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
   localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
   localparam int ACC_W    = PROD_I_W + 2;
   localparam int TRUNC_W  = ACC_W - FRAC_W;

   // state word of the error memory: previous error over integral
   localparam int PI_W = ERR_W + SUM_W;

   localparam logic [AXIS_W-1:0] AXIS_YAW   = AXIS_W'(0);
   localparam logic [AXIS_W-1:0] AXIS_PITCH = AXIS_W'(1);
   localparam logic [AXIS_W-1:0] AXIS_ROLL  = AXIS_W'(2);
   localparam logic [AXIS_W-1:0] AXIS_LAST  = AXIS_W'(NUM_AXES - 1);

   localparam logic [CLAMP_W-1:0] PULSE_MIN = 11'd1000;
   localparam logic [CLAMP_W-1:0] PULSE_MAX = 11'd2000;
   localparam logic signed [ERR_W-1:0] ONE_DEGREE = 17'sd256;

   // setpoint = floor(d * 512 / 125) - 2048, d = pulse - 1000;
   // d * 512 / 125 done as d * ceil(2^27 / 125) >> 18, exact for d <= 1000
   localparam int SP_PROD_W = 31;
   localparam int SP_SHIFT  = 18;
   localparam logic [SP_PROD_W-1:0] SP_RECIP = 31'd1073742;
   localparam logic signed [ERR_W-1:0] SP_OFFSET = 17'sd2048;

   localparam logic [GAINS_W-1:0] GAINS_YAW_RST   = 48'd21990232556032;
   localparam logic [GAINS_W-1:0] GAINS_PITCH_RST = 48'd28587306516890;
   localparam logic [GAINS_W-1:0] GAINS_ROLL_RST  = 48'd30786329248064;
   localparam logic [ILIM_W-1:0]  ILIM_YAW_RST    = 24'd16777215;
   localparam logic [ILIM_W-1:0]  ILIM_TILT_RST   = 24'd102400;
   localparam logic [DLIM_W-1:0]  DLIM_YAW_RST    = 10'd450;
   localparam logic [DLIM_W-1:0]  DLIM_TILT_RST   = 10'd600;
   localparam logic [CLAMP_W-1:0] ARM_RST         = 11'd1150;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAINS_YAW,
      CSR_GAINS_PITCH,
      CSR_GAINS_ROLL,
      CSR_ILIM_YAW,
      CSR_ILIM_TILT,
      CSR_DLIM_YAW,
      CSR_DLIM_TILT,
      CSR_ARM_THRESHOLD
   } csr_index_type;

   typedef struct packed {
      logic [NUM_AXES-1:0][GAINS_W-1:0] gains;
      logic [ILIM_W-1:0]                ilim_yaw;
      logic [ILIM_W-1:0]                ilim_tilt;
      logic [DLIM_W-1:0]                dlim_yaw;
      logic [DLIM_W-1:0]                dlim_tilt;
      logic [CLAMP_W-1:0]               arm_threshold;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      gains:         {GAINS_ROLL_RST, GAINS_PITCH_RST, GAINS_YAW_RST},
      ilim_yaw:      ILIM_YAW_RST,
      ilim_tilt:     ILIM_TILT_RST,
      dlim_yaw:      DLIM_YAW_RST,
      dlim_tilt:     DLIM_TILT_RST,
      arm_threshold: ARM_RST
   };

   typedef struct packed {
      logic                    valid;
      logic [AXIS_W-1:0]       axis;
      logic                    last;
      logic                    armed;
      logic                    big;
      logic [CLAMP_W-1:0]      thr;
      logic signed [ERR_W-1:0] err;
      logic [GAIN_W-1:0]       kp;
      logic [GAIN_W-1:0]       ki;
      logic [GAIN_W-1:0]       kd;
      logic [ILIM_W-1:0]       ilim;
      logic [DLIM_W-1:0]       dlim;
   } issue_type;

   typedef struct packed {
      logic                      valid;
      logic [AXIS_W-1:0]         axis;
      logic                      last;
      logic                      armed;
      logic [CLAMP_W-1:0]        thr;
      logic signed [DRIVE_W-1:0] drive;
   } axis_result_type;

   function automatic logic [CLAMP_W-1:0] clamp_pulse(input logic [PULSE_W-1:0] p);
      logic [CLAMP_W-1:0] r;
      if (p < PULSE_W'(PULSE_MIN)) begin
         r = PULSE_MIN;
      end else if (p > PULSE_W'(PULSE_MAX)) begin
         r = PULSE_MAX;
      end else begin
         r = p[CLAMP_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [ERR_W-1:0] axis_error(
      input logic [PULSE_W-1:0]        pulse,
      input logic signed [ANGLE_W-1:0] meas
   );
      logic [CLAMP_W-1:0]      p;
      logic [DIFF_W-1:0]       d;
      logic [SP_PROD_W-1:0]    prod;
      logic signed [ERR_W-1:0] sp;
      p    = clamp_pulse(pulse);
      d    = DIFF_W'(p - PULSE_MIN);
      prod = SP_PROD_W'(d) * SP_RECIP;
      sp   = ERR_W'($signed({1'b0, prod[SP_PROD_W-1:SP_SHIFT]})) - SP_OFFSET;
      return ERR_W'(meas) - sp;
   endfunction

endpackage

// ----- rtl/tapa_req_if.sv -----
`timescale 1ns / 1ps

interface tapa_req_if;
   logic valid;
   logic ready;
   logic [tapa_pkg::PULSE_W-1:0]        throttle_pulse;
   logic [tapa_pkg::PULSE_W-1:0]        yaw_pulse;
   logic [tapa_pkg::PULSE_W-1:0]        pitch_pulse;
   logic [tapa_pkg::PULSE_W-1:0]        roll_pulse;
   logic signed [tapa_pkg::ANGLE_W-1:0] measured_yaw;
   logic signed [tapa_pkg::ANGLE_W-1:0] measured_pitch;
   logic signed [tapa_pkg::ANGLE_W-1:0] measured_roll;

   modport source (
      output valid, throttle_pulse, yaw_pulse, pitch_pulse, roll_pulse,
             measured_yaw, measured_pitch, measured_roll,
      input  ready
   );

   modport sink (
      input  valid, throttle_pulse, yaw_pulse, pitch_pulse, roll_pulse,
             measured_yaw, measured_pitch, measured_roll,
      output ready
   );
endinterface

// ----- rtl/tapa_rsp_if.sv -----
`timescale 1ns / 1ps

interface tapa_rsp_if;
   logic valid;
   logic ready;
   logic signed [tapa_pkg::DRIVE_W-1:0] yaw_drive;
   logic signed [tapa_pkg::DRIVE_W-1:0] pitch_drive;
   logic signed [tapa_pkg::DRIVE_W-1:0] roll_drive;
   logic [tapa_pkg::CLAMP_W-1:0]        throttle_out;
   logic                                armed;

   modport source (
      output valid, yaw_drive, pitch_drive, roll_drive, throttle_out, armed,
      input  ready
   );

   modport sink (
      input  valid, yaw_drive, pitch_drive, roll_drive, throttle_out, armed,
      output ready
   );
endinterface

// ----- rtl/tapa_front.sv -----
`timescale 1ns / 1ps

module tapa_front (
   input  logic                clock,
   input  logic                reset,
   tapa_req_if.sink            req_ch,
   input  logic                adv,
   input  tapa_pkg::cfg_type   cfg,
   output tapa_pkg::issue_type issue
);

   logic                                item_valid_ff, item_valid_in;
   logic [tapa_pkg::AXIS_W-1:0]         axis_ff, axis_in;
   logic                                armed_ff, armed_in;
   logic                                big_ff, big_in;
   logic [tapa_pkg::CLAMP_W-1:0]        thr_ff, thr_in;
   logic signed [tapa_pkg::ERR_W-1:0]   err_ff [tapa_pkg::NUM_AXES];
   logic signed [tapa_pkg::ERR_W-1:0]   err_new [tapa_pkg::NUM_AXES];
   logic signed [tapa_pkg::ERR_W-1:0]   err_in [tapa_pkg::NUM_AXES];
   logic                                last;
   logic                                accept;
   logic [tapa_pkg::GAINS_W-1:0]        gains_sel;

   assign last         = (axis_ff == tapa_pkg::AXIS_LAST);
   // next transaction may land as the last axis of the current one issues
   assign req_ch.ready = adv && (!item_valid_ff || last);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      err_new[tapa_pkg::AXIS_YAW]   = tapa_pkg::axis_error(req_ch.yaw_pulse,
                                                           req_ch.measured_yaw);
      err_new[tapa_pkg::AXIS_PITCH] = tapa_pkg::axis_error(req_ch.pitch_pulse,
                                                           req_ch.measured_pitch);
      err_new[tapa_pkg::AXIS_ROLL]  = tapa_pkg::axis_error(req_ch.roll_pulse,
                                                           req_ch.measured_roll);
   end

   always_comb begin
      thr_in   = thr_ff;
      armed_in = armed_ff;
      big_in   = big_ff;
      err_in   = err_ff;
      if (accept) begin
         thr_in   = tapa_pkg::clamp_pulse(req_ch.throttle_pulse);
         armed_in = (thr_in >= cfg.arm_threshold);
         big_in   = 1'b0;
         for (int a = 0; a < tapa_pkg::NUM_AXES; a++) begin
            err_in[a] = err_new[a];
            if ((err_new[a] > tapa_pkg::ONE_DEGREE) ||
                (err_new[a] < -tapa_pkg::ONE_DEGREE)) begin
               big_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      axis_in       = axis_ff;
      if (adv) begin
         if (!item_valid_ff || last) begin
            item_valid_in = accept;
            axis_in       = '0;
         end else begin
            axis_in = axis_ff + tapa_pkg::AXIS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         axis_ff       <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         axis_ff       <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_ff   <= thr_in;
      armed_ff <= armed_in;
      big_ff   <= big_in;
      err_ff   <= err_in;
   end

   assign gains_sel = cfg.gains[axis_ff];

   always_comb begin
      issue.valid = item_valid_ff;
      issue.axis  = axis_ff;
      issue.last  = last;
      issue.armed = armed_ff;
      issue.big   = big_ff;
      issue.thr   = thr_ff;
      issue.err   = err_ff[axis_ff];
      issue.kp    = gains_sel[tapa_pkg::GAIN_W-1:0];
      issue.ki    = gains_sel[2*tapa_pkg::GAIN_W-1:tapa_pkg::GAIN_W];
      issue.kd    = gains_sel[3*tapa_pkg::GAIN_W-1:2*tapa_pkg::GAIN_W];
      issue.ilim  = (axis_ff == tapa_pkg::AXIS_YAW) ? cfg.ilim_yaw : cfg.ilim_tilt;
      issue.dlim  = (axis_ff == tapa_pkg::AXIS_YAW) ? cfg.dlim_yaw : cfg.dlim_tilt;
   end

endmodule

// ----- rtl/tapa_axis_pipe.sv -----
`timescale 1ns / 1ps

// Shared per-axis datapath. Axis state lives in two small memories:
// previous error and integral (read at issue, written back one stage later)
// and the held drive (read in D, written back in E). An axis comes round
// again only after the other two axes have issued, so every read sees the last
// write to its entry and no forwarding path is needed.
module tapa_axis_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  tapa_pkg::issue_type       issue,
   output tapa_pkg::axis_result_type result
);

   typedef struct packed {
      logic [tapa_pkg::AXIS_W-1:0]         axis;
      logic                                last;
      logic                                armed;
      logic                                big;
      logic [tapa_pkg::CLAMP_W-1:0]        thr;
      logic [tapa_pkg::DLIM_W-1:0]         dlim;
      logic signed [tapa_pkg::ERR_W-1:0]   err;
      logic signed [tapa_pkg::SUM_W-1:0]   isum;
      logic signed [tapa_pkg::DERIV_W-1:0] deriv;
      logic [tapa_pkg::GAIN_W-1:0]         kp;
      logic [tapa_pkg::GAIN_W-1:0]         ki;
      logic [tapa_pkg::GAIN_W-1:0]         kd;
   } c_stage_type;

   typedef struct packed {
      logic [tapa_pkg::AXIS_W-1:0]          axis;
      logic                                 last;
      logic                                 armed;
      logic                                 big;
      logic [tapa_pkg::CLAMP_W-1:0]         thr;
      logic [tapa_pkg::DLIM_W-1:0]          dlim;
      logic signed [tapa_pkg::PROD_P_W-1:0] prod_p;
      logic signed [tapa_pkg::PROD_I_W-1:0] prod_i;
      logic signed [tapa_pkg::PROD_D_W-1:0] prod_d;
   } d_stage_type;

   typedef struct packed {
      logic [tapa_pkg::AXIS_W-1:0]       axis;
      logic                              last;
      logic                              armed;
      logic                              big;
      logic [tapa_pkg::CLAMP_W-1:0]      thr;
      logic [tapa_pkg::DLIM_W-1:0]       dlim;
      logic signed [tapa_pkg::ACC_W-1:0] acc;
   } e_stage_type;

   logic b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff;
   tapa_pkg::issue_type b_ff;
   c_stage_type         c_ff, c_in;
   d_stage_type         d_ff, d_in;
   e_stage_type         e_ff, e_in;

   // error memory
   logic [tapa_pkg::PI_W-1:0]     pi_mem [tapa_pkg::NUM_AXES];
   logic [tapa_pkg::NUM_AXES-1:0] pi_set_ff;
   logic [tapa_pkg::PI_W-1:0]     pi_rd_ff;
   logic                          pi_rd_set_ff;
   logic                          pi_we;
   logic [tapa_pkg::PI_W-1:0]     pi_wdata;

   // held drive memory
   logic [tapa_pkg::DRIVE_W-1:0]  held_mem [tapa_pkg::NUM_AXES];
   logic [tapa_pkg::NUM_AXES-1:0] held_set_ff;
   logic [tapa_pkg::DRIVE_W-1:0]  held_rd_ff;
   logic                          held_rd_set_ff;
   logic                          held_we;

   logic signed [tapa_pkg::ERR_W-1:0]   prev;
   logic signed [tapa_pkg::SUM_W-1:0]   sum_old;
   logic signed [tapa_pkg::SUM_W:0]     sum_raw;
   logic signed [tapa_pkg::SUM_W:0]     ilim_s;
   logic signed [tapa_pkg::SUM_W:0]     sum_sat;
   logic signed [tapa_pkg::TRUNC_W-1:0] trunc;
   logic                                round_up;
   logic signed [tapa_pkg::TRUNC_W-1:0] drive_raw;
   logic signed [tapa_pkg::TRUNC_W-1:0] dlim_s;
   logic signed [tapa_pkg::TRUNC_W-1:0] drive_sat;
   logic signed [tapa_pkg::DRIVE_W-1:0] drive;
   logic signed [tapa_pkg::DRIVE_W-1:0] held;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= issue.valid;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_ff <= issue;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
      end
   end

   // ---- error memory: read at issue, write back from B ----
   always_ff @(posedge clock) begin
      if (adv) begin
         pi_rd_ff <= pi_mem[issue.axis];
         if (pi_we) begin
            pi_mem[b_ff.axis] <= pi_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pi_set_ff    <= '0;
         pi_rd_set_ff <= 1'b0;
      end else if (adv) begin
         pi_rd_set_ff <= pi_set_ff[issue.axis];
         if (pi_we) begin
            pi_set_ff[b_ff.axis] <= 1'b1;
         end
      end
   end

   // ---- B: integral and derivative ----
   always_comb begin
      prev    = pi_rd_set_ff ? $signed(pi_rd_ff[tapa_pkg::PI_W-1:tapa_pkg::SUM_W]) : '0;
      sum_old = pi_rd_set_ff ? $signed(pi_rd_ff[tapa_pkg::SUM_W-1:0]) : '0;
      sum_raw = (tapa_pkg::SUM_W+1)'(sum_old) + (tapa_pkg::SUM_W+1)'(b_ff.err);
      ilim_s  = $signed({2'b00, b_ff.ilim});
      if (sum_raw > ilim_s) begin
         sum_sat = ilim_s;
      end else if (sum_raw < -ilim_s) begin
         sum_sat = -ilim_s;
      end else begin
         sum_sat = sum_raw;
      end

      c_in.axis  = b_ff.axis;
      c_in.last  = b_ff.last;
      c_in.armed = b_ff.armed;
      c_in.big   = b_ff.big;
      c_in.thr   = b_ff.thr;
      c_in.dlim  = b_ff.dlim;
      c_in.err   = b_ff.err;
      c_in.isum  = sum_sat[tapa_pkg::SUM_W-1:0];
      c_in.deriv = tapa_pkg::DERIV_W'(b_ff.err) - tapa_pkg::DERIV_W'(prev);
      c_in.kp    = b_ff.kp;
      c_in.ki    = b_ff.ki;
      c_in.kd    = b_ff.kd;
   end

   // disarmed transactions leave error and integral untouched
   assign pi_we    = adv && b_vld_ff && b_ff.armed;
   assign pi_wdata = {b_ff.err, c_in.isum};

   // ---- C: the three gain products ----
   always_comb begin
      d_in.axis   = c_ff.axis;
      d_in.last   = c_ff.last;
      d_in.armed  = c_ff.armed;
      d_in.big    = c_ff.big;
      d_in.thr    = c_ff.thr;
      d_in.dlim   = c_ff.dlim;
      d_in.prod_p = tapa_pkg::PROD_P_W'($signed({1'b0, c_ff.kp}))
                    * tapa_pkg::PROD_P_W'(c_ff.err);
      d_in.prod_i = tapa_pkg::PROD_I_W'($signed({1'b0, c_ff.ki}))
                    * tapa_pkg::PROD_I_W'(c_ff.isum);
      d_in.prod_d = tapa_pkg::PROD_D_W'($signed({1'b0, c_ff.kd}))
                    * tapa_pkg::PROD_D_W'(c_ff.deriv);
   end

   // ---- D: sum, and held drive read ----
   always_comb begin
      e_in.axis  = d_ff.axis;
      e_in.last  = d_ff.last;
      e_in.armed = d_ff.armed;
      e_in.big   = d_ff.big;
      e_in.thr   = d_ff.thr;
      e_in.dlim  = d_ff.dlim;
      e_in.acc   = tapa_pkg::ACC_W'(d_ff.prod_p) + tapa_pkg::ACC_W'(d_ff.prod_i)
                   + tapa_pkg::ACC_W'(d_ff.prod_d);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         held_rd_ff <= held_mem[d_ff.axis];
         if (held_we) begin
            held_mem[e_ff.axis] <= drive;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_set_ff    <= '0;
         held_rd_set_ff <= 1'b0;
      end else if (adv) begin
         held_rd_set_ff <= held_set_ff[d_ff.axis];
         if (held_we) begin
            held_set_ff[e_ff.axis] <= 1'b1;
         end
      end
   end

   // ---- E: truncate toward zero, pick held drive, saturate, zero when disarmed ----
   always_comb begin
      held      = held_rd_set_ff ? $signed(held_rd_ff) : '0;
      round_up  = e_ff.acc[tapa_pkg::ACC_W-1] && (e_ff.acc[tapa_pkg::FRAC_W-1:0] != '0);
      trunc     = $signed(e_ff.acc[tapa_pkg::ACC_W-1:tapa_pkg::FRAC_W])
                  + $signed({{(tapa_pkg::TRUNC_W-1){1'b0}}, round_up});
      drive_raw = e_ff.big ? trunc : tapa_pkg::TRUNC_W'(held);
      dlim_s    = $signed({{(tapa_pkg::TRUNC_W-tapa_pkg::DLIM_W){1'b0}}, e_ff.dlim});
      if (drive_raw > dlim_s) begin
         drive_sat = dlim_s;
      end else if (drive_raw < -dlim_s) begin
         drive_sat = -dlim_s;
      end else begin
         drive_sat = drive_raw;
      end
      drive = e_ff.armed ? drive_sat[tapa_pkg::DRIVE_W-1:0] : '0;
   end

   assign held_we = adv && e_vld_ff;

   always_comb begin
      result.valid = e_vld_ff;
      result.axis  = e_ff.axis;
      result.last  = e_ff.last;
      result.armed = e_ff.armed;
      result.thr   = e_ff.thr;
      result.drive = drive;
   end

endmodule

// ----- rtl/three_axis_pid_attitude_core.sv -----
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// req_ch   in   valid/ready        four pulse widths, three measured angles
// rsp_ch   out  valid/ready        three drives, clamped throttle, armed
// csr_*    in   csr_we, no ready   csr_index selects register, csr_wdata
//
// The three axes take turns on one shared datapath and on one read and one
// write port of each state memory; a new transaction may enter as the last
// axis of the one before issues, so transactions overlap in the pipeline.
// Reset (synchronous) restores register defaults and clears the state memory
// valid bits, so all axis state reads as zero; no clearing pass is needed.
// A response not taken stalls the pipeline only when the next one finishes.

module three_axis_pid_attitude_core (
   input  logic                            clock,
   input  logic                            reset,
   tapa_req_if.sink                        req_ch,
   tapa_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [tapa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tapa_pkg::CSR_W-1:0]      csr_wdata
);

   tapa_pkg::cfg_type         cfg_ff, cfg_in;
   tapa_pkg::issue_type       issue;
   tapa_pkg::axis_result_type res;
   logic                      adv;
   logic                      load;

   logic                                  out_vld_ff, out_vld_in;
   logic signed [tapa_pkg::DRIVE_W-1:0]   part_ff [tapa_pkg::NUM_AXES];
   logic signed [tapa_pkg::DRIVE_W-1:0]   out_drive_ff [tapa_pkg::NUM_AXES];
   logic [tapa_pkg::CLAMP_W-1:0]          out_thr_ff;
   logic                                  out_armed_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (tapa_pkg::csr_index_type'(csr_index))
            tapa_pkg::CSR_GAINS_YAW:     cfg_in.gains[tapa_pkg::AXIS_YAW]   = csr_wdata;
            tapa_pkg::CSR_GAINS_PITCH:   cfg_in.gains[tapa_pkg::AXIS_PITCH] = csr_wdata;
            tapa_pkg::CSR_GAINS_ROLL:    cfg_in.gains[tapa_pkg::AXIS_ROLL]  = csr_wdata;
            tapa_pkg::CSR_ILIM_YAW:      cfg_in.ilim_yaw  = csr_wdata[tapa_pkg::ILIM_W-1:0];
            tapa_pkg::CSR_ILIM_TILT:     cfg_in.ilim_tilt = csr_wdata[tapa_pkg::ILIM_W-1:0];
            tapa_pkg::CSR_DLIM_YAW:      cfg_in.dlim_yaw  = csr_wdata[tapa_pkg::DLIM_W-1:0];
            tapa_pkg::CSR_DLIM_TILT:     cfg_in.dlim_tilt = csr_wdata[tapa_pkg::DLIM_W-1:0];
            tapa_pkg::CSR_ARM_THRESHOLD: begin
               cfg_in.arm_threshold = csr_wdata[tapa_pkg::CLAMP_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tapa_pkg::CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // hold everything only when a finished transaction has nowhere to go
   assign adv  = !(out_vld_ff && !rsp_ch.ready && res.valid && res.last);
   assign load = adv && res.valid && res.last;

   tapa_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .adv    (adv),
      .cfg    (cfg_ff),
      .issue  (issue)
   );

   tapa_axis_pipe u_axis_pipe (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .issue  (issue),
      .result (res)
   );

   always_comb begin
      out_vld_in = out_vld_ff;
      if (load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res.valid) begin
         part_ff[res.axis] <= res.drive;
      end
      if (load) begin
         for (int a = 0; a < tapa_pkg::NUM_AXES; a++) begin
            out_drive_ff[a] <= (tapa_pkg::AXIS_W'(a) == res.axis) ? res.drive : part_ff[a];
         end
         out_thr_ff   <= res.thr;
         out_armed_ff <= res.armed;
      end
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.yaw_drive    = out_drive_ff[tapa_pkg::AXIS_YAW];
   assign rsp_ch.pitch_drive  = out_drive_ff[tapa_pkg::AXIS_PITCH];
   assign rsp_ch.roll_drive   = out_drive_ff[tapa_pkg::AXIS_ROLL];
   assign rsp_ch.throttle_out = out_thr_ff;
   assign rsp_ch.armed        = out_armed_ff;

endmodule

// ----- rtl/tapa_checker.sv -----
`timescale 1ns / 1ps

module tapa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [tapa_pkg::DRIVE_W-1:0] rsp_yaw_drive,
   input logic signed [tapa_pkg::DRIVE_W-1:0] rsp_pitch_drive,
   input logic signed [tapa_pkg::DRIVE_W-1:0] rsp_roll_drive,
   input logic [tapa_pkg::CLAMP_W-1:0]        rsp_throttle_out,
   input logic                                rsp_armed
);

   // a stalled transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_yaw_drive)
         && $stable(rsp_pitch_drive) && $stable(rsp_roll_drive)
         && $stable(rsp_throttle_out) && $stable(rsp_armed))
      else $error("response changed while stalled");

   // disarmed transactions carry no correction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_armed |-> (rsp_yaw_drive == '0) && (rsp_pitch_drive == '0)
         && (rsp_roll_drive == '0))
      else $error("non-zero drive while disarmed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_throttle_out >= tapa_pkg::PULSE_MIN)
         && (rsp_throttle_out <= tapa_pkg::PULSE_MAX))
      else $error("throttle outside pulse range");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind three_axis_pid_attitude_core tapa_checker u_tapa_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_yaw_drive    (rsp_ch.yaw_drive),
   .rsp_pitch_drive  (rsp_ch.pitch_drive),
   .rsp_roll_drive   (rsp_ch.roll_drive),
   .rsp_throttle_out (rsp_ch.throttle_out),
   .rsp_armed        (rsp_ch.armed)
);

// ----- test/tapa_attitude_checker.sv -----
`timescale 1ns / 1ps

module tapa_attitude_checker (
   input  logic                           clock,
   input  logic                           reset,
   tapa_req_if                            req_ch,
   tapa_rsp_if                            rsp_ch,
   input  logic                           csr_we,
   input  logic [tapa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tapa_pkg::CSR_W-1:0]     csr_wdata,
   output int                             mismatches,
   output int                             outstanding
);

   localparam longint PULSE_FLOOR = 1000;
   localparam longint PULSE_CEIL  = 2000;
   localparam longint SP_HALF     = 2048;
   localparam longint ONE_DEG     = 256;
   localparam longint Q16_ONE     = 65536;

   typedef struct packed {
      logic [tapa_pkg::NUM_AXES-1:0][tapa_pkg::DRIVE_W-1:0] drive;
      logic [tapa_pkg::CLAMP_W-1:0]                         throttle;
      logic                                                 armed;
   } tick_result_type;

   tapa_pkg::cfg_type                   regs;
   logic signed [tapa_pkg::ERR_W:0]     last_error [tapa_pkg::NUM_AXES];
   logic signed [tapa_pkg::SUM_W-1:0]   integral   [tapa_pkg::NUM_AXES];
   logic signed [tapa_pkg::DRIVE_W-1:0] held       [tapa_pkg::NUM_AXES];
   tick_result_type                     expected_ticks [$];
   int                                  fail_total;

   function automatic logic [tapa_pkg::CLAMP_W-1:0] clamp_width(
      input logic [tapa_pkg::PULSE_W-1:0] w
   );
      if (longint'(w) < PULSE_FLOOR) return tapa_pkg::CLAMP_W'(PULSE_FLOOR);
      if (longint'(w) > PULSE_CEIL) return tapa_pkg::CLAMP_W'(PULSE_CEIL);
      return w[tapa_pkg::CLAMP_W-1:0];
   endfunction

   function automatic longint clip(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // one control tick: updates the loop state and returns the drives it produces
   function automatic tick_result_type advance_loop(
      input logic [tapa_pkg::PULSE_W-1:0]        thr_w, yaw_w, pitch_w, roll_w,
      input logic signed [tapa_pkg::ANGLE_W-1:0] ang_y, ang_p, ang_r
   );
      tick_result_type                     r;
      logic [tapa_pkg::PULSE_W-1:0]        width [tapa_pkg::NUM_AXES];
      logic signed [tapa_pkg::ANGLE_W-1:0] angle [tapa_pkg::NUM_AXES];
      longint                              err   [tapa_pkg::NUM_AXES];
      longint                              setpoint, ilim, dlim, isum, deriv, drv, kp, ki, kd;
      logic                                big;
      width      = '{yaw_w, pitch_w, roll_w};
      angle      = '{ang_y, ang_p, ang_r};
      r.throttle = clamp_width(thr_w);
      r.armed    = 1'b0;
      r.drive    = '0;
      big        = 1'b0;
      if (r.throttle < regs.arm_threshold) begin
         // disarmed: only the held drives are cleared
         for (int a = 0; a < tapa_pkg::NUM_AXES; a++) held[a] = '0;
         return r;
      end
      for (int a = 0; a < tapa_pkg::NUM_AXES; a++) begin
         setpoint = (longint'(clamp_width(width[a])) - PULSE_FLOOR) * 512 / 125 - SP_HALF;
         err[a]   = longint'(angle[a]) - setpoint;
         if (err[a] > ONE_DEG || err[a] < -ONE_DEG) big = 1'b1;
      end
      r.armed = 1'b1;
      for (int a = 0; a < tapa_pkg::NUM_AXES; a++) begin
         ilim  = (a == 0) ? longint'(regs.ilim_yaw) : longint'(regs.ilim_tilt);
         dlim  = (a == 0) ? longint'(regs.dlim_yaw) : longint'(regs.dlim_tilt);
         isum  = clip(longint'(integral[a]) + err[a], ilim);
         deriv = err[a] - longint'(last_error[a]);
         drv   = longint'(held[a]);
         integral[a]   = tapa_pkg::SUM_W'(isum);
         last_error[a] = (tapa_pkg::ERR_W + 1)'(err[a]);
         if (big) begin
            kp  = longint'(regs.gains[a][tapa_pkg::GAIN_W-1:0]);
            ki  = longint'(regs.gains[a][2*tapa_pkg::GAIN_W-1:tapa_pkg::GAIN_W]);
            kd  = longint'(regs.gains[a][3*tapa_pkg::GAIN_W-1:2*tapa_pkg::GAIN_W]);
            drv = (kp * err[a] + ki * isum + kd * deriv) / Q16_ONE;
         end
         // held drives are re-limited too
         drv        = clip(drv, dlim);
         held[a]    = tapa_pkg::DRIVE_W'(drv);
         r.drive[a] = tapa_pkg::DRIVE_W'(drv);
      end
      return r;
   endfunction

   task automatic report_tick(input string what, input tick_result_type want,
                              input tick_result_type got);
      fail_total++;
      if (fail_total <= 10) begin
         $display("%t %s: expected yaw %0d pitch %0d roll %0d thr %0d armed %0b", $time, what,
                  $signed(want.drive[0]), $signed(want.drive[1]), $signed(want.drive[2]),
                  want.throttle, want.armed);
         $display("%t %s:      got yaw %0d pitch %0d roll %0d thr %0d armed %0b", $time, what,
                  $signed(got.drive[0]), $signed(got.drive[1]), $signed(got.drive[2]),
                  got.throttle, got.armed);
      end
   endtask

   always @(posedge clock) begin
      tick_result_type want, got;
      if (reset) begin
         regs.gains[0]      = 48'd21990232556032;
         regs.gains[1]      = 48'd28587306516890;
         regs.gains[2]      = 48'd30786329248064;
         regs.ilim_yaw      = 24'd16777215;
         regs.ilim_tilt     = 24'd102400;
         regs.dlim_yaw      = 10'd450;
         regs.dlim_tilt     = 10'd600;
         regs.arm_threshold = 11'd1150;
         for (int a = 0; a < tapa_pkg::NUM_AXES; a++) begin
            last_error[a] = '0;
            integral[a]   = '0;
            held[a]       = '0;
         end
         expected_ticks.delete();
         fail_total = 0;
      end else begin
         if (csr_we) begin
            case (tapa_pkg::csr_index_type'(csr_index))
               tapa_pkg::CSR_GAINS_YAW:   regs.gains[0] = csr_wdata[tapa_pkg::GAINS_W-1:0];
               tapa_pkg::CSR_GAINS_PITCH: regs.gains[1] = csr_wdata[tapa_pkg::GAINS_W-1:0];
               tapa_pkg::CSR_GAINS_ROLL:  regs.gains[2] = csr_wdata[tapa_pkg::GAINS_W-1:0];
               tapa_pkg::CSR_ILIM_YAW:    regs.ilim_yaw = csr_wdata[tapa_pkg::ILIM_W-1:0];
               tapa_pkg::CSR_ILIM_TILT:   regs.ilim_tilt = csr_wdata[tapa_pkg::ILIM_W-1:0];
               tapa_pkg::CSR_DLIM_YAW:    regs.dlim_yaw = csr_wdata[tapa_pkg::DLIM_W-1:0];
               tapa_pkg::CSR_DLIM_TILT:   regs.dlim_tilt = csr_wdata[tapa_pkg::DLIM_W-1:0];
               tapa_pkg::CSR_ARM_THRESHOLD: begin
                  regs.arm_threshold = csr_wdata[tapa_pkg::CLAMP_W-1:0];
               end
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_ticks.push_back(advance_loop(
               req_ch.throttle_pulse, req_ch.yaw_pulse, req_ch.pitch_pulse, req_ch.roll_pulse,
               req_ch.measured_yaw, req_ch.measured_pitch, req_ch.measured_roll));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.drive[0] = rsp_ch.yaw_drive;
            got.drive[1] = rsp_ch.pitch_drive;
            got.drive[2] = rsp_ch.roll_drive;
            got.throttle = rsp_ch.throttle_out;
            got.armed    = rsp_ch.armed;
            if (expected_ticks.size() == 0) begin
               report_tick("unexpected transaction", '0, got);
            end else begin
               want = expected_ticks.pop_front();
               if (want.drive[0] !== got.drive[0] || want.drive[1] !== got.drive[1] ||
                   want.drive[2] !== got.drive[2] || want.throttle !== got.throttle ||
                   want.armed !== got.armed) begin
                  report_tick("drive mismatch", want, got);
               end
            end
         end
      end
      mismatches  <= fail_total;
      outstanding <= expected_ticks.size();
   end

endmodule

// ----- test/tb_three_axis_pid_attitude_core.sv -----
`timescale 1ns / 1ps

module tb_three_axis_pid_attitude_core;

   localparam int SEGMENTS      = 11;
   localparam int SEGMENT_TICKS = 50;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [tapa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [tapa_pkg::CSR_W-1:0]     csr_wdata;
   int                             send_idle_pct = 37;
   int                             recv_idle_pct = 60;
   int                             cycle_count   = 0;
   int                             mismatches;
   int                             outstanding;

   tapa_req_if req_ch ();
   tapa_rsp_if rsp_ch ();

   three_axis_pid_attitude_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tapa_attitude_checker drive_check (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_three_axis_pid_attitude_core: done, errors");
         $finish;
      end
   end

   task automatic send_tick(input logic [tapa_pkg::PULSE_W-1:0] thr, yaw_p, pitch_p, roll_p,
                            input logic [tapa_pkg::ANGLE_W-1:0] ang_y, ang_p, ang_r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid          <= 1'b1;
      req_ch.throttle_pulse <= thr;
      req_ch.yaw_pulse      <= yaw_p;
      req_ch.pitch_pulse    <= pitch_p;
      req_ch.roll_pulse     <= roll_p;
      req_ch.measured_yaw   <= ang_y;
      req_ch.measured_pitch <= ang_p;
      req_ch.measured_roll  <= ang_r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // angle roughly at the setpoint of the given pulse, plus a random offset
   function automatic logic [tapa_pkg::ANGLE_W-1:0] near_angle(
      input logic [tapa_pkg::PULSE_W-1:0] p, input int spread
   );
      return tapa_pkg::ANGLE_W'((int'(p) - 1500) * 4 + int'($urandom_range(0, 2 * spread))
                                - spread);
   endfunction

   task automatic send_random_tick();
      logic [tapa_pkg::PULSE_W-1:0] thr, yp, pp, rp;
      logic [tapa_pkg::ANGLE_W-1:0] ay, ap, ar;
      int                           mode, spread;
      mode = int'($urandom_range(0, 9));
      thr  = tapa_pkg::PULSE_W'($urandom);
      yp   = tapa_pkg::PULSE_W'($urandom);
      pp   = tapa_pkg::PULSE_W'($urandom);
      rp   = tapa_pkg::PULSE_W'($urandom);
      ay   = tapa_pkg::ANGLE_W'($urandom);
      ap   = tapa_pkg::ANGLE_W'($urandom);
      ar   = tapa_pkg::ANGLE_W'($urandom);
      if (mode == 1) begin
         thr = tapa_pkg::PULSE_W'($urandom_range(0, 1150));
      end else if (mode >= 2) begin
         // plausible flight: pulses near range, angles near setpoint
         spread = (mode <= 5) ? 500 : 280;
         thr    = tapa_pkg::PULSE_W'($urandom_range(1000, 2100));
         yp     = tapa_pkg::PULSE_W'($urandom_range(960, 2040));
         pp     = tapa_pkg::PULSE_W'($urandom_range(960, 2040));
         rp     = tapa_pkg::PULSE_W'($urandom_range(960, 2040));
         ay     = near_angle(yp, spread);
         ap     = near_angle(pp, spread);
         ar     = near_angle(rp, spread);
      end
      send_tick(thr, yp, pp, rp, ay, ap, ar);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input tapa_pkg::csr_index_type idx,
                            input logic [tapa_pkg::CSR_W-1:0] value, input int width);
      logic [tapa_pkg::CSR_W-1:0] junk;
      junk = tapa_pkg::CSR_W'({$urandom, $urandom});
      // unused upper bits sometimes carry junk
      if ($urandom_range(0, 1)) value = value | (junk << width);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   function automatic logic [tapa_pkg::GAIN_W-1:0] mixed_gain();
      return ($urandom_range(0, 3) == 0) ? tapa_pkg::GAIN_W'($urandom)
                                         : tapa_pkg::GAIN_W'($urandom_range(0, 1500));
   endfunction

   task automatic apply_setting(input int k);
      logic [tapa_pkg::GAINS_W-1:0] gain [tapa_pkg::NUM_AXES];
      logic [tapa_pkg::ILIM_W-1:0]  ilim_y, ilim_t;
      logic [tapa_pkg::DLIM_W-1:0]  dlim_y, dlim_t;
      logic [tapa_pkg::CLAMP_W-1:0] arm;
      wait_idle();
      for (int a = 0; a < tapa_pkg::NUM_AXES; a++) begin
         gain[a] = {mixed_gain(), mixed_gain(), mixed_gain()};
      end
      ilim_y = ($urandom_range(0, 3) == 0) ? tapa_pkg::ILIM_W'($urandom)
                                           : tapa_pkg::ILIM_W'($urandom_range(0, 200000));
      ilim_t = ($urandom_range(0, 3) == 0) ? tapa_pkg::ILIM_W'($urandom)
                                           : tapa_pkg::ILIM_W'($urandom_range(0, 200000));
      dlim_y = tapa_pkg::DLIM_W'($urandom);
      dlim_t = tapa_pkg::DLIM_W'($urandom);
      arm    = tapa_pkg::CLAMP_W'($urandom_range(1000, 1400));
      case (k)
         0: begin
            for (int a = 0; a < tapa_pkg::NUM_AXES; a++) gain[a] = '1;
            ilim_y = '1;
            ilim_t = '1;
            dlim_y = '1;
            dlim_t = '1;
            arm    = 11'd1000;
         end
         1: begin
            for (int a = 0; a < tapa_pkg::NUM_AXES; a++) gain[a] = '0;
            ilim_y = '0;
            ilim_t = '0;
            dlim_y = '0;
            dlim_t = '0;
            arm    = '0;
         end
         2: begin
            for (int a = 0; a < tapa_pkg::NUM_AXES; a++) gain[a] = '1;
            ilim_y = '0;
            ilim_t = '0;
            dlim_y = '1;
            dlim_t = '1;
            arm    = 11'd2000;
         end
         3: arm = '1;   // above the clamp: never arms
         default: ;
      endcase
      write_reg(tapa_pkg::CSR_GAINS_YAW, gain[0], tapa_pkg::GAINS_W);
      write_reg(tapa_pkg::CSR_GAINS_PITCH, gain[1], tapa_pkg::GAINS_W);
      write_reg(tapa_pkg::CSR_GAINS_ROLL, gain[2], tapa_pkg::GAINS_W);
      write_reg(tapa_pkg::CSR_ILIM_YAW, tapa_pkg::CSR_W'(ilim_y), tapa_pkg::ILIM_W);
      write_reg(tapa_pkg::CSR_ILIM_TILT, tapa_pkg::CSR_W'(ilim_t), tapa_pkg::ILIM_W);
      write_reg(tapa_pkg::CSR_DLIM_YAW, tapa_pkg::CSR_W'(dlim_y), tapa_pkg::DLIM_W);
      write_reg(tapa_pkg::CSR_DLIM_TILT, tapa_pkg::CSR_W'(dlim_t), tapa_pkg::DLIM_W);
      write_reg(tapa_pkg::CSR_ARM_THRESHOLD, tapa_pkg::CSR_W'(arm), tapa_pkg::CLAMP_W);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= '0;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.throttle_pulse <= '0;
      req_ch.yaw_pulse      <= '0;
      req_ch.pitch_pulse    <= '0;
      req_ch.roll_pulse     <= '0;
      req_ch.measured_yaw   <= '0;
      req_ch.measured_pitch <= '0;
      req_ch.measured_roll  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed ticks on the power-on settings
      send_tick(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_tick(16'd1149, 16'd1500, 16'd1500, 16'd1500, 16'd0, 16'd0, 16'd0);
      send_tick(16'd1150, 16'd1500, 16'd1500, 16'd1500, 16'd0, 16'd0, 16'd0);
      // largest positive error, repeated until the tilt integral saturates
      repeat (4) send_tick(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      repeat (2) send_tick(16'd2000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
      // exactly one degree is still small: held drives repeat
      send_tick(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd256, -16'sd256, 16'd0);
      send_tick(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd257, 16'd0, 16'd0);
      send_tick(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd0, 16'd0, -16'sd257);
      send_tick(16'd1500, 16'd999, 16'd1000, 16'd2001, 16'd0, 16'd0, 16'd0);
      send_tick(16'd1500, 16'd2000, 16'd1000, 16'd1001, 16'd2048, -16'sd2048, -16'sd2044);
      send_tick(16'd999, 16'd1500, 16'd1500, 16'd1500, 16'h7FFF, 16'h8000, 16'd0);
      send_tick(16'd1500, 16'd1500, 16'd1500, 16'd1500, 16'd100, -16'sd100, 16'd0);
      send_tick(16'h8000, 16'hFFFF, 16'h8000, 16'd0, 16'h5555, 16'hAAAA, 16'h0F0F);
      send_tick(16'd65535, 16'h7FFF, 16'h03E8, 16'h07D0, 16'h00FF, 16'hFF00, 16'h8001);

      for (int s = 0; s < SEGMENTS; s++) begin
         if (s == 4) begin
            send_idle_pct = 60;
            recv_idle_pct = 37;
         end
         if (s == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (s > 0) apply_setting(s - 1);
         repeat (SEGMENT_TICKS) send_random_tick();
      end

      wait_idle();
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_three_axis_pid_attitude_core: done, clean");
      end else begin
         $display("tb_three_axis_pid_attitude_core: done, errors");
      end
      $finish;
   end

endmodule
